[rtl/fsif_pkg.sv]
// Shared types, constants and character table for the integer format block.
package fsif_pkg;

    // Argument width after masking; the argument word itself is always 32 bits
    localparam int ARG_WIDTH = 32;
    localparam int WORD_W    = 32;
    localparam logic [WORD_W-1:0] ARG_MASK = (ARG_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
        WORD_W'((64'd1 << ARG_WIDTH) - 64'd1);

    // Digit counts and register widths of the conversion datapath
    localparam int DEC_DIGITS  = 10;
    localparam int HEX_NIBBLES = 8;
    localparam int BCD_W       = 4 * DEC_DIGITS;
    localparam int CNT_W       = $clog2(WORD_W + 1);

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_D       = 8'h64;

    // Digit characters, decimal digits share the first ten entries
    localparam logic [7:0] HEX_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [7:0]        fmt_byte;
        logic [WORD_W-1:0] arg_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_FMT,
        LD_ARG,
        LD_HEX,
        LD_DEC
    } load_t;

    typedef struct packed {
        load_t load;
        logic  conv_step;
        logic  skip_step;
        logic  emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic top_zero;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/fsif_dp.sv]
// Datapath: argument capture, binary to BCD conversion, digit shifter and output register.
module fsif_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  fsif_pkg::in_word_t  in_word,
    input  fsif_pkg::ctrl_cmd_t cmd,
    output fsif_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output fsif_pkg::out_word_t out_word
);
    import fsif_pkg::*;

    logic [7:0]        byte_reg, byte_next;
    logic              is_char_reg, is_char_next;
    logic [BCD_W-1:0]  data_reg, data_next;
    logic [WORD_W-1:0] bin_reg, bin_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    logic [WORD_W-1:0] arg_m;
    logic [BCD_W-1:0]  bcd_adj;
    logic [3:0]        top_nib;
    logic [7:0]        cur_byte;

    assign arg_m   = in_word.arg_value & ARG_MASK;
    assign top_nib = data_reg[BCD_W-1 -: 4];

    // Add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (data_reg[i*4 +: 4] >= 4'd5) ?
                data_reg[i*4 +: 4] + 4'd3 : data_reg[i*4 +: 4];
        end
    end

    // Select the character to send
    assign cur_byte = is_char_reg ? byte_reg : HEX_TABLE[top_nib];

    assign status.cnt_last = (cnt_reg == CNT_W'(1));
    assign status.top_zero = (top_nib == 4'd0);
    assign status.out_free = !out_valid_reg || !out_stall;

    // Next values of the working registers
    always_comb
    begin
        byte_next    = byte_reg;
        is_char_next = is_char_reg;
        data_next    = data_reg;
        bin_next     = bin_reg;
        cnt_next     = cnt_reg;
        case (cmd.load)
            LD_FMT:
            begin
                byte_next    = in_word.fmt_byte;
                is_char_next = 1'b1;
                cnt_next     = CNT_W'(1);
            end
            LD_ARG:
            begin
                byte_next    = arg_m[7:0];
                is_char_next = 1'b1;
                cnt_next     = CNT_W'(1);
            end
            LD_HEX:
            begin
                data_next    = {arg_m, {(BCD_W - WORD_W){1'b0}}};
                is_char_next = 1'b0;
                cnt_next     = CNT_W'(HEX_NIBBLES);
            end
            LD_DEC:
            begin
                data_next    = '0;
                bin_next     = arg_m;
                is_char_next = 1'b0;
                cnt_next     = CNT_W'(WORD_W);
            end
            default:
            begin
            end
        endcase
        if (cmd.conv_step)
        begin
            data_next = {bcd_adj[BCD_W-2:0], bin_reg[WORD_W-1]};
            bin_next  = {bin_reg[WORD_W-2:0], 1'b0};
            cnt_next  = status.cnt_last ? CNT_W'(DEC_DIGITS) : cnt_reg - CNT_W'(1);
        end
        if (cmd.skip_step || cmd.emit)
        begin
            data_next = {data_reg[BCD_W-5:0], 4'd0};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    // Load the output register on emit, drop the word once taken
    always_comb
    begin
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next            = 1'b1;
            out_word_next.out_byte    = cur_byte;
            out_word_next.last_of_run = status.cnt_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the payload registers
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        is_char_reg  <= is_char_next;
        data_reg     <= data_next;
        bin_reg      <= bin_next;
        out_word_reg <= out_word_next;
    end

    // Hold the control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[rtl/fsif_ctrl.sv]
// Controller: percent flag, format decode and sequencing of conversion and emission.
module fsif_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           fmt_byte,
    input  fsif_pkg::dp_status_t status,
    output fsif_pkg::ctrl_cmd_t  cmd
);
    import fsif_pkg::*;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;

    assign in_stall = (state_reg != ST_IDLE);

    // Decode the format byte and step through the conversion
    always_comb
    begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        cmd.load      = LD_NONE;
        cmd.conv_step = 1'b0;
        cmd.skip_step = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (fmt_byte == CH_NUL)
                    begin
                        pending_next = 1'b0;
                        cmd.load     = LD_FMT;
                        state_next   = ST_EMIT;
                    end
                    else if (!pending_reg)
                    begin
                        if (fmt_byte == CH_PERCENT)
                        begin
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            cmd.load   = LD_FMT;
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        case (fmt_byte)
                            CH_C:
                            begin
                                cmd.load   = LD_ARG;
                                state_next = ST_EMIT;
                            end
                            CH_X:
                            begin
                                cmd.load   = LD_HEX;
                                state_next = ST_EMIT;
                            end
                            CH_D:
                            begin
                                cmd.load   = LD_DEC;
                                state_next = ST_CONV;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the final digit
                if (status.top_zero && !status.cnt_last)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.cnt_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and percent flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

[rtl/format_string_integer_formatter.sv]
// Top level of the integer printf-style formatter.
//
// Input channel: in_valid / in_stall carry one word per format byte, with the
// argument word a conversion at that byte would use. Output channel:
// out_valid / out_stall carry one character per word, last_of_run set on the
// final character an input word produces.
// One input word is worked on at a time; in_stall is high while it is busy.
// Work per input word:
//   '%' or an unknown conversion: accepted with no output
//   ordinary byte, terminator, %c: one character
//   %x: eight hex digits, one per cycle while the output is not stalled
//   %d: accept, a shift-and-add-three BCD conversion of the argument,
//       skip leading zeros and move to emission, then one digit per cycle
//       through the output register while the output is not stalled.
// Characters reach the port through the output register, loaded in ST_EMIT.
// While out_stall is high the output register holds its word and emission
// pauses; the next input word may be accepted while the final character of
// the previous one still waits.
// Reset clears the percent flag, the controller and the output valid.
module format_string_integer_formatter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fsif_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output fsif_pkg::out_word_t out_word
);
    import fsif_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fsif_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .fmt_byte (in_word.fmt_byte),
        .status   (status),
        .cmd      (cmd)
    );

    fsif_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

[rtl/fsif_checker.sv]
// Port-level checker for the formatter, bound to the top level.
module fsif_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input fsif_pkg::in_word_t  in_word,
    input logic                out_valid,
    input logic                out_stall,
    input fsif_pkg::out_word_t out_word
);
    import fsif_pkg::*;

    // No word offered just after a reset edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output word valid during reset");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // A zero character is always the final one of its run
    a_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.out_byte == CH_NUL) |-> out_word.last_of_run)
        else $error("zero character not marked last");

    // Input stays stalled while a run is unfinished
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.last_of_run |-> in_stall)
        else $error("input accepted in the middle of a run");

    // A terminator always makes the block busy emitting it
    a_nul_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_word.fmt_byte == CH_NUL) |=> in_stall)
        else $error("terminator accepted without output");

endmodule

bind format_string_integer_formatter fsif_checker u_fsif_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
